@@ rtl/sqrtn_pkg.sv @@
package sqrtn_pkg;

  // Field widths of the input and result words.
  localparam int unsigned RADICAND_W = 32;
  localparam int unsigned ROOT_W     = 24;

  // Fraction bits of the 16.16 format; the radicand is widened by this much.
  localparam int unsigned FRAC_BITS  = 16;

  // Width of the widened radicand and of the Newton estimate.
  localparam int unsigned DIV_W      = RADICAND_W + FRAC_BITS;

  // Default cap on the number of Newton updates.
  localparam int unsigned ITERATION_LIMIT_DEF = 32;

  // Sequencer states of the Newton loop.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD
  } sqrtn_state_e;

endpackage

@@ rtl/sqrtn_div.sv @@
module sqrtn_div #(
  parameter int unsigned Width = sqrtn_pkg::DIV_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [Width-1:0] quotient_o
);

  import sqrtn_pkg::*;

  localparam int unsigned CntW = (Width > 1) ? $clog2(Width) : 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [Width-1:0] rem_q, rem_d;
  logic [Width-1:0] quo_q, quo_d;
  logic [Width-1:0] dvs_q, dvs_d;

  // Partial remainder with the next dividend bit shifted in.
  logic [Width:0]   rem_sh;
  logic [Width+1:0] diff;
  logic             ge;

  assign rem_sh = {rem_q, quo_q[Width-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign ge     = ~diff[Width+1];

  // One quotient bit per cycle, restoring scheme; the dividend register
  // fills with quotient bits from the right as it empties on the left.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[Width-1:0] : rem_sh[Width-1:0];
      quo_d = {quo_q[Width-2:0], ge};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(Width - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/fixed_point_sqrt_newton_unit.sv @@
// Square root of a signed 16.16 word, returned as an unsigned 8.16 root in
// 24 bits; zero or negative words give a root of 0 in the cycle after start.
// A positive word is widened to 48 bits and refined by Newton steps
// r = (r + x / r) / 2 until a step leaves r unchanged or ITERATION_LIMIT
// steps are done. Each step runs a division in the shared radix-2 divider,
// hands the quotient over and then does the add and the convergence test.
// A zero or negative word leaves busy low. For a positive word busy is high
// from just after the
// word's acceptance until its result is shown; valid_o marks the root for a
// single cycle and must be taken then, since the block cannot hold it.
module fixed_point_sqrt_newton_unit #(
  parameter int unsigned ITERATION_LIMIT = sqrtn_pkg::ITERATION_LIMIT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [sqrtn_pkg::RADICAND_W-1:0] radicand_i,
  output logic                                 valid_o,
  output logic [sqrtn_pkg::ROOT_W-1:0]         root_o
);

  import sqrtn_pkg::*;

  localparam int unsigned CntW = $clog2(ITERATION_LIMIT + 1);

  sqrtn_state_e state_q, state_d;

  logic [DIV_W-1:0]  x_q, x_d;
  logic [DIV_W-1:0]  est_q, est_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              valid_q, valid_d;
  logic [ROOT_W-1:0] root_q, root_d;

  logic              accept;
  logic              positive;
  logic [DIV_W-1:0]  x_new;
  logic [DIV_W:0]    sum;
  logic [DIV_W-1:0]  est_next;
  logic              stop;

  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [DIV_W-1:0]  div_divisor;
  logic              div_busy;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;

  // Input decode: positive means sign clear and not zero.
  assign accept   = start && !busy;
  assign positive = !radicand_i[RADICAND_W-1] && (radicand_i != '0);
  assign x_new    = {radicand_i, {FRAC_BITS{1'b0}}};

  // Newton update and its stop test.
  assign sum      = {1'b0, est_q} + {1'b0, div_quo};
  assign est_next = sum[DIV_W:1];
  assign stop     = (est_next == est_q) || (cnt_q == CntW'(ITERATION_LIMIT - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && positive) state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_UPD;
      ST_UPD:  state_d = stop ? ST_IDLE : ST_DIV;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and strobe control.
  always_comb begin
    x_d          = x_q;
    est_d        = est_q;
    cnt_d        = cnt_q;
    valid_d      = 1'b0;
    root_d       = root_q;
    div_start    = 1'b0;
    div_dividend = x_q;
    div_divisor  = est_next;
    unique case (state_q)
      ST_IDLE: begin
        div_dividend = x_new;
        div_divisor  = x_new;
        if (accept) begin
          x_d   = x_new;
          est_d = x_new;
          cnt_d = '0;
          if (positive) begin
            div_start = 1'b1;
          end else begin
            valid_d = 1'b1;
            root_d  = '0;
          end
        end
      end
      ST_DIV: begin
      end
      ST_UPD: begin
        est_d = est_next;
        cnt_d = cnt_q + CntW'(1);
        if (stop) begin
          valid_d = 1'b1;
          root_d  = est_next[ROOT_W-1:0];
        end else begin
          div_start = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  sqrtn_div #(
    .Width (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    est_q  <= est_d;
    root_q <= root_d;
  end

  assign busy    = (state_q != ST_IDLE);
  assign valid_o = valid_q;
  assign root_o  = root_q;

  // A result word appears only once the sequencer is back at rest.
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> !busy)
    else $error("result word shown while busy");

  // Non-positive words give a zero root on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !positive) |=> (valid_o && root_o == '0))
    else $error("non-positive word did not give a zero root");

  // While waiting on a division the divider is working or just finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_busy || div_done))
    else $error("waiting on an idle divider");

  // The divider never runs outside a Newton step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!div_busy && !div_done))
    else $error("divider active while idle");

  // The step count never passes the limit, and the estimate is never zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (cnt_q < CntW'(ITERATION_LIMIT) && est_q != '0))
    else $error("step count or estimate out of range");

endmodule
